[hdl/tlc_pkg.sv]
// Shared types, constants and decode functions for the traffic light countdown display.
package tlc_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int CNT_W      = 7;
    localparam int DIG_W      = 4;
    localparam int SEG_W      = 7;
    localparam int IDX_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int STORE_DEPTH = NUM_DIGITS - 1;

    localparam logic               MODE_TICK = 1'b0;
    localparam logic               MODE_SCAN = 1'b1;
    localparam logic [SEG_W-1:0]   SEG_BLANK = 7'h7F;
    localparam logic [NUM_DIGITS-1:0] EN_ALL_OFF = 5'h1F;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_GREEN  = 2'd1,
        PH_YELLOW = 2'd2
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RED_TIME    = 3'd0,
        REG_GREEN_TIME  = 3'd1,
        REG_YELLOW_TIME = 3'd2,
        REG_RUN_ENABLE  = 3'd3,
        REG_MODE_DIGIT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] red_time;
        logic [CNT_W-1:0] green_time;
        logic [CNT_W-1:0] yellow_time;
        logic             run_enable;
        logic [DIG_W-1:0] mode_digit;
    } cfg_t;

    // Packed so that up_light lands in the lowest bits of the output tdata.
    typedef struct packed {
        logic [NUM_DIGITS-1:0] digit_enable_n;
        logic [SEG_W-1:0]      segments_n;
        logic [1:0]            left_light;
        logic [1:0]            up_light;
    } result_t;

    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIG_W-1:0] v);
        logic [SEG_W-1:0] s;
        case (v)
            4'd0: s = 7'h40;
            4'd1: s = 7'h79;
            4'd2: s = 7'h24;
            4'd3: s = 7'h30;
            4'd4: s = 7'h19;
            4'd5: s = 7'h12;
            4'd6: s = 7'h02;
            4'd7: s = 7'h78;
            4'd8: s = 7'h00;
            4'd9: s = 7'h10;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic phase_t next_phase(input phase_t p);
        phase_t n;
        case (p)
            PH_RED:   n = PH_GREEN;
            PH_GREEN: n = PH_YELLOW;
            default:  n = PH_RED;
        endcase
        return n;
    endfunction

    // Tens digit of a 7-bit count: multiply by 205 and drop 11 bits (exact below 1029).
    function automatic logic [DIG_W-1:0] tens_of(input logic [CNT_W-1:0] c);
        logic [15:0] prod;
        prod = 16'(c) * 16'd205;
        return prod[14:11];
    endfunction

endpackage

[hdl/traffic_light_countdown_display_top.sv]
// Top level of the traffic light countdown display: stream ports, input and output registers.
// Usage:
//   Each input transaction on the s_ channel is either a countdown tick (s_tuser = 0) or
//   a display scan of digit s_tdata[2:0] (s_tuser = 1). Every transaction yields exactly
//   one output transaction on the m_ channel carrying both lamp phases and the segment and
//   digit-enable patterns as they stand after that transaction.
//   Configuration (durations, run enable, mode digit) is written through cfg_wr_en,
//   cfg_index and cfg_wdata while no transaction is in flight; durations take effect at
//   the next reload of a counter.
// Timing:
//   A transaction accepted at one clock edge is captured in the input register; its result
//   is computed and registered once the output register has room, and m_tvalid then rises.
//   One transaction per cycle is sustained while m_tready stays high; the single pass from
//   input register to output register sets that figure.
// Reset and backpressure:
//   aresetn (synchronous, active low) empties both registers and restores the default
//   registers, phases (up red, left green), counters, digits and blank display latches.
//   While m_tready is low the output register holds its result; the input register still
//   takes one more transaction, and s_tready drops only once both registers are full.
module traffic_light_countdown_display_top
    import tlc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] digit_index, rest zero
    input  logic                  s_tuser,   // [0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // [1:0] up_light, [3:2] left_light,
                                             // [10:4] segments_n, [15:11] digit_enable_n
);

    cfg_t             cfg;
    result_t          result;
    logic             in_valid_reg, in_valid_next;
    logic             in_mode_reg;
    logic [IDX_W-1:0] in_idx_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg;
    logic             advance, s_accept;

    tlc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    tlc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_go   (advance),
        .item_mode (in_mode_reg),
        .item_idx  (in_idx_reg),
        .result    (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= s_tuser;
            in_idx_reg  <= s_tdata[IDX_W-1:0];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A held transaction in the input register must reach the output once there is room.
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!out_valid_reg || m_tready)) |=> out_valid_reg)
        else $error("input transaction did not move to the output register");

    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready dropped with room in the pipeline");

    a_lamps_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3))
        else $error("lamp phase code three on the output");

    a_one_digit_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(~m_tdata[15:11]) <= 1)
        else $error("more than one display digit enabled");

endmodule

[hdl/tlc_cfg_regs.sv]
// Configuration register file written through the plain write port.
module tlc_cfg_regs
    import tlc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_ADDR_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_reg_t'(wr_index))
                REG_RED_TIME:    cfg_next.red_time    = wr_data;
                REG_GREEN_TIME:  cfg_next.green_time  = wr_data;
                REG_YELLOW_TIME: cfg_next.yellow_time = wr_data;
                REG_RUN_ENABLE:  cfg_next.run_enable  = wr_data[0];
                REG_MODE_DIGIT:  cfg_next.mode_digit  = wr_data[DIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_time    <= 7'd5;
            cfg_reg.green_time  <= 7'd3;
            cfg_reg.yellow_time <= 7'd2;
            cfg_reg.run_enable  <= 1'b1;
            cfg_reg.mode_digit  <= 4'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tlc_core.sv]
// Light phases, countdown counters, digit store and display latches.
module tlc_core
    import tlc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             item_go,
    input  logic             item_mode,
    input  logic [IDX_W-1:0] item_idx,
    output result_t          result
);

    phase_t                up_phase_reg, up_phase_next;
    phase_t                left_phase_reg, left_phase_next;
    logic [CNT_W-1:0]      up_count_reg, up_count_next;
    logic [CNT_W-1:0]      left_count_reg, left_count_next;
    logic [DIG_W-1:0]      digit_reg [STORE_DEPTH];
    logic [DIG_W-1:0]      digit_next [STORE_DEPTH];
    logic [SEG_W-1:0]      seg_reg, seg_next;
    logic [NUM_DIGITS-1:0] en_reg, en_next;

    phase_t           up_ph_rl, left_ph_rl;
    logic [CNT_W-1:0] up_cnt_rl, left_cnt_rl;
    logic [DIG_W-1:0] up_tens, left_tens;
    logic [CNT_W-1:0] up_tens_x10, left_tens_x10;
    logic [CNT_W-1:0] up_units, left_units;
    logic             do_tick, do_scan, idx_in_range;
    logic [IDX_W-1:0] idx_m1;
    logic [DIG_W-1:0] scan_value;

    function automatic logic [CNT_W-1:0] duration(input phase_t p, input cfg_t c);
        logic [CNT_W-1:0] d;
        case (p)
            PH_RED:    d = c.red_time;
            PH_GREEN:  d = c.green_time;
            PH_YELLOW: d = c.yellow_time;
            default:   d = '0;
        endcase
        return d;
    endfunction

    // A counter that has run down to zero moves its direction on and reloads.
    always_comb begin
        up_ph_rl    = up_phase_reg;
        up_cnt_rl   = up_count_reg;
        left_ph_rl  = left_phase_reg;
        left_cnt_rl = left_count_reg;
        if (up_count_reg == '0) begin
            up_ph_rl  = next_phase(up_phase_reg);
            up_cnt_rl = duration(up_ph_rl, cfg);
        end
        if (left_count_reg == '0) begin
            left_ph_rl  = next_phase(left_phase_reg);
            left_cnt_rl = duration(left_ph_rl, cfg);
        end
    end

    assign up_tens       = tens_of(up_cnt_rl);
    assign left_tens     = tens_of(left_cnt_rl);
    assign up_tens_x10   = CNT_W'({up_tens, 3'b000}) + CNT_W'({up_tens, 1'b0});
    assign left_tens_x10 = CNT_W'({left_tens, 3'b000}) + CNT_W'({left_tens, 1'b0});
    assign up_units      = up_cnt_rl - up_tens_x10;
    assign left_units    = left_cnt_rl - left_tens_x10;

    assign do_tick      = item_go && (item_mode == MODE_TICK) && cfg.run_enable;
    assign do_scan      = item_go && (item_mode == MODE_SCAN);
    assign idx_in_range = item_idx < IDX_W'(NUM_DIGITS);
    assign idx_m1       = item_idx - IDX_W'(1);
    assign scan_value   = (item_idx == '0) ? cfg.mode_digit : digit_reg[idx_m1[1:0]];

    always_comb begin
        up_phase_next   = up_phase_reg;
        left_phase_next = left_phase_reg;
        up_count_next   = up_count_reg;
        left_count_next = left_count_reg;
        digit_next      = digit_reg;
        seg_next        = seg_reg;
        en_next         = en_reg;
        if (do_tick) begin
            up_phase_next   = up_ph_rl;
            left_phase_next = left_ph_rl;
            up_count_next   = (up_cnt_rl != '0) ? up_cnt_rl - CNT_W'(1) : up_cnt_rl;
            left_count_next = (left_cnt_rl != '0) ? left_cnt_rl - CNT_W'(1) : left_cnt_rl;
            digit_next[0]   = up_tens;
            digit_next[1]   = up_units[DIG_W-1:0];
            digit_next[2]   = left_tens;
            digit_next[3]   = left_units[DIG_W-1:0];
        end
        if (do_scan) begin
            if (idx_in_range) begin
                en_next  = EN_ALL_OFF & ~(NUM_DIGITS'(1) << item_idx);
                seg_next = seg_decode(scan_value);
            end else begin
                seg_next = SEG_BLANK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_phase_reg   <= PH_RED;
            left_phase_reg <= PH_GREEN;
            up_count_reg   <= 7'd5;
            left_count_reg <= 7'd3;
            digit_reg[0]   <= 4'd0;
            digit_reg[1]   <= 4'd6;
            digit_reg[2]   <= 4'd0;
            digit_reg[3]   <= 4'd4;
            seg_reg        <= SEG_BLANK;
            en_reg         <= EN_ALL_OFF;
        end else begin
            up_phase_reg   <= up_phase_next;
            left_phase_reg <= left_phase_next;
            up_count_reg   <= up_count_next;
            left_count_reg <= left_count_next;
            digit_reg      <= digit_next;
            seg_reg        <= seg_next;
            en_reg         <= en_next;
        end
    end

    // The result carries the state as it stands once this transaction is done.
    assign result.up_light       = up_phase_next;
    assign result.left_light     = left_phase_next;
    assign result.segments_n     = seg_next;
    assign result.digit_enable_n = en_next;

endmodule

[dv/tb.sv]
// Testbench for the traffic light countdown display: stream stimulus checked by a scoreboard.
`timescale 1ns / 100ps

import tlc_pkg::*;

// Tracks lamp phases, counters, digit store and display latches, and checks every result.
class tlc_scoreboard;
    logic [CNT_W-1:0] red_time, green_time, yellow_time;
    logic             run_on;
    logic [DIG_W-1:0] mode_digit;
    logic [CNT_W-1:0] up_count, left_count;
    phase_t           up_phase, left_phase;
    logic [DIG_W-1:0] digits [STORE_DEPTH];
    logic [SEG_W-1:0] seg_latch;
    logic [NUM_DIGITS-1:0] en_latch;
    logic [SEG_W-1:0] glyph [10];
    result_t          expected_displays [$];
    int               errors;

    function new();
        red_time    = 7'd5;
        green_time  = 7'd3;
        yellow_time = 7'd2;
        run_on      = 1'b1;
        mode_digit  = 4'd1;
        up_count    = 7'd5;
        left_count  = 7'd3;
        up_phase    = PH_RED;
        left_phase  = PH_GREEN;
        digits      = '{4'd0, 4'd6, 4'd0, 4'd4};
        seg_latch   = SEG_BLANK;
        en_latch    = EN_ALL_OFF;
        glyph = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10};
        errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        case (r)
            REG_RED_TIME:    red_time    = v;
            REG_GREEN_TIME:  green_time  = v;
            REG_YELLOW_TIME: yellow_time = v;
            REG_RUN_ENABLE:  run_on      = v[0];
            REG_MODE_DIGIT:  mode_digit  = v[DIG_W-1:0];
            default: ;
        endcase
    endfunction

    function phase_t following(phase_t p);
        case (p)
            PH_RED:   return PH_GREEN;
            PH_GREEN: return PH_YELLOW;
            default:  return PH_RED;
        endcase
    endfunction

    function logic [CNT_W-1:0] duration(phase_t p);
        case (p)
            PH_RED:    return red_time;
            PH_GREEN:  return green_time;
            PH_YELLOW: return yellow_time;
            default:   return '0;
        endcase
    endfunction

    function logic [SEG_W-1:0] pattern(logic [DIG_W-1:0] v);
        return (v > 4'd9) ? SEG_BLANK : glyph[v];
    endfunction

    function int pending();
        return expected_displays.size();
    endfunction

    // Applies one accepted input transaction and queues the display it should produce.
    function void note_item(logic mode, logic [IDX_W-1:0] idx);
        result_t r;
        logic [DIG_W-1:0] v;
        if (mode == MODE_TICK) begin
            if (run_on) begin
                if (left_count == 0) begin
                    left_phase = following(left_phase);
                    left_count = duration(left_phase);
                end
                if (up_count == 0) begin
                    up_phase = following(up_phase);
                    up_count = duration(up_phase);
                end
                digits[0] = 4'(up_count / 10);
                digits[1] = 4'(up_count % 10);
                digits[2] = 4'(left_count / 10);
                digits[3] = 4'(left_count % 10);
                if (up_count != 0) up_count--;
                if (left_count != 0) left_count--;
            end
        end else if (idx >= NUM_DIGITS) begin
            seg_latch = SEG_BLANK;
        end else begin
            en_latch  = ~(NUM_DIGITS'(1) << idx);
            v         = (idx == 0) ? mode_digit : digits[idx - 1];
            seg_latch = pattern(v);
        end
        r.up_light       = up_phase;
        r.left_light     = left_phase;
        r.segments_n     = seg_latch;
        r.digit_enable_n = en_latch;
        expected_displays.push_back(r);
    endfunction

    task report_mismatch(string msg);
        if (errors < 100) $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_display(result_t got);
        result_t want;
        if (expected_displays.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_displays.pop_front();
        if (got.up_light != want.up_light || got.left_light != want.left_light ||
            got.segments_n != want.segments_n || got.digit_enable_n != want.digit_enable_n)
            report_mismatch($sformatf(
                "up %0d/%0d left %0d/%0d seg %h/%h en %h/%h (got/expected)",
                got.up_light, want.up_light, got.left_light, want.left_light,
                got.segments_n, want.segments_n, got.digit_enable_n, want.digit_enable_n));
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;

    tlc_scoreboard sb = new();
    bit            calm = 1'b0;
    int            cycles = 0;

    traffic_light_countdown_display_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_display(result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(8 - IDX_W){1'b0}}, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(mode, idx);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Writes all five registers; only called with nothing in flight.
    task automatic apply_setting(int unsigned red, int unsigned green, int unsigned yellow,
                                 int unsigned run, int unsigned digit);
        cfg_reg_t              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{REG_RED_TIME, REG_GREEN_TIME, REG_YELLOW_TIME, REG_RUN_ENABLE,
                 REG_MODE_DIGIT};
        vals = '{CFG_DATA_W'(red), CFG_DATA_W'(green), CFG_DATA_W'(yellow),
                 CFG_DATA_W'(run), CFG_DATA_W'(digit)};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Ticks a little more often than scans so the counters keep cycling the phases.
    task automatic send_random(int n, int pause_at);
        logic [IDX_W-1:0] idx;
        logic             mode;
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) drain();
            mode = ($urandom_range(0, 99) < 55) ? MODE_TICK : MODE_SCAN;
            idx  = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, 4))
                                              : IDX_W'($urandom_range(5, 7));
            send_item(mode, idx);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset contents of every digit, including indexes past the last digit, then ticks and scans.
        for (int i = 0; i < 8; i++) send_item(MODE_SCAN, IDX_W'(i));
        for (int i = 0; i < 6; i++) send_item(MODE_TICK, IDX_W'(i));
        for (int i = 1; i < 5; i++) send_item(MODE_SCAN, IDX_W'(i));
        drain();

        // Stopped: ticks change nothing, and a mode digit above nine is blank.
        apply_setting(5, 3, 2, 0, 12);
        send_item(MODE_TICK, 3'd7);
        send_item(MODE_TICK, 3'd0);
        send_item(MODE_SCAN, 3'd0);
        send_item(MODE_SCAN, 3'd2);
        drain();

        apply_setting(5, 3, 2, 1, 1);
        send_random(100, 50);

        // Zero durations make the phases change on every tick.
        apply_setting(0, 0, 0, 1, 9);
        send_random(60, -1);

        calm = 1'b1;
        apply_setting(99, 1, 99, 1, 15);
        send_random(150, -1);
        calm = 1'b0;

        // Counts above 99 give a tens digit that decodes blank.
        apply_setting(127, 127, 127, 1, 0);
        send_random(140, -1);

        apply_setting(7, 4, 9, 0, 8);
        send_random(40, -1);

        apply_setting($urandom_range(1, 99), $urandom_range(1, 99), $urandom_range(1, 99), 1,
                      $urandom_range(0, 15));
        send_random(60, -1);

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/tlc_pkg.sv
hdl/tlc_cfg_regs.sv
hdl/tlc_core.sv
hdl/traffic_light_countdown_display_top.sv
dv/tb.sv
